FILE: design/uapq_pkg.sv
// shared types, codes and default sizes for the unordered array priority queue
// no dependencies; imported by the cell, the top level and the checker
package uapq_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEPTH_DEF    = 8;
    localparam int PRI_W_DEF    = 8;
    localparam int VAL_W_DEF    = 32;

    // fixed field widths of the ports
    localparam int VALUE_FLD_W  = 32;
    localparam int PRI_FLD_W    = 8;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 4;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DEQUEUED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

    typedef struct packed {
        logic                          operation;
        logic signed [VALUE_FLD_W-1:0] value_in;
        logic        [PRI_FLD_W-1:0]   priority_in;
    } t_in;

    typedef struct packed {
        logic        [STATUS_W-1:0]    status;
        logic signed [VALUE_FLD_W-1:0] value_out;
        logic        [PRI_FLD_W-1:0]   priority_out;
        logic        [OCC_W-1:0]       occupancy;
    } t_out;

    // per-cell control from the sequencer
    typedef struct packed {
        logic wr;     // load the incoming pair
        logic shift;  // take the neighbor's pair from above
        logic valid;  // cell holds a live entry
    } t_cell_ctl;

endpackage

FILE: design/unordered_array_priority_queue.sv
// enqueue, full and empty results appear in the cycle after the transaction is accepted;
// a dequeue first lets the max token ripple through the registers of the cell chain
// and then commits the result and the compacting shift once the output is free
// one enqueue per cycle while the output is free; no input is taken during a dequeue
// reset: synchronous active low, clears the entry count and handshake state; stored pairs
// are not cleared and no clearing pass runs, so the block is ready right after reset
module unordered_array_priority_queue
    import uapq_pkg::*;
#(
    parameter int DEPTH          = DEPTH_DEF,
    parameter int PRIORITY_WIDTH = PRI_W_DEF,
    parameter int VALUE_WIDTH    = VAL_W_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_scan, n_scan;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    logic w_out_free;
    logic w_in_acc;
    logic w_full;
    logic w_enq;
    logic w_deq_fire;

    logic [VALUE_WIDTH-1:0]    w_wr_val;
    logic [PRIORITY_WIDTH-1:0] w_wr_pri;

    t_cell_ctl                 w_ctl   [DEPTH];
    logic [VALUE_WIDTH-1:0]    w_val   [DEPTH];
    logic [PRIORITY_WIDTH-1:0] w_pri   [DEPTH];
    logic                      w_tok_v [DEPTH+1];
    logic [PRIORITY_WIDTH-1:0] w_tok_p [DEPTH+1];
    logic [VALUE_WIDTH-1:0]    w_tok_d [DEPTH+1];
    logic [IDX_W-1:0]          w_tok_i [DEPTH+1];

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_enq      = w_in_acc && (i_in.operation == OP_ENQUEUE) && !w_full;
    assign w_deq_fire = (r_state == S_DONE) && w_out_free;

    assign w_wr_val = VALUE_WIDTH'($unsigned(i_in.value_in));
    assign w_wr_pri = PRIORITY_WIDTH'(i_in.priority_in);

    // head of the token chain carries nothing
    assign w_tok_v[0] = 1'b0;
    assign w_tok_p[0] = '0;
    assign w_tok_d[0] = '0;
    assign w_tok_i[0] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_WIDTH-1:0]    w_nb_val;
        logic [PRIORITY_WIDTH-1:0] w_nb_pri;

        if (i < DEPTH - 1) begin : g_nb
            assign w_nb_val = w_val[i+1];
            assign w_nb_pri = w_pri[i+1];
        end else begin : g_top
            assign w_nb_val = '0;
            assign w_nb_pri = '0;
        end

        assign w_ctl[i].valid = (CNT_W'(i) < r_count);
        assign w_ctl[i].wr    = w_enq && (CNT_W'(i) == r_count);
        assign w_ctl[i].shift = w_deq_fire && (IDX_W'(i) >= w_tok_i[DEPTH])
                              && (CNT_W'(i + 1) < r_count);

        uapq_cell #(
            .IDX   (i),
            .PRI_W (PRIORITY_WIDTH),
            .VAL_W (VALUE_WIDTH),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl[i]),
            .i_wr_val    (w_wr_val),
            .i_wr_pri    (w_wr_pri),
            .i_nb_val    (w_nb_val),
            .i_nb_pri    (w_nb_pri),
            .i_tok_valid (w_tok_v[i]),
            .i_tok_pri   (w_tok_p[i]),
            .i_tok_val   (w_tok_d[i]),
            .i_tok_idx   (w_tok_i[i]),
            .o_val       (w_val[i]),
            .o_pri       (w_pri[i]),
            .o_tok_valid (w_tok_v[i+1]),
            .o_tok_pri   (w_tok_p[i+1]),
            .o_tok_val   (w_tok_d[i+1]),
            .o_tok_idx   (w_tok_i[i+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.operation == OP_ENQUEUE) begin
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        if (w_full) begin
                            n_out.status    = STAT_FULL;
                            n_out.occupancy = OCC_W'(r_count);
                        end else begin
                            n_count         = r_count + CNT_W'(1);
                            n_out.status    = STAT_ENQUEUED;
                            n_out.occupancy = OCC_W'(r_count + CNT_W'(1));
                        end
                    end else if (r_count == '0) begin
                        n_out_valid     = 1'b1;
                        n_out           = '0;
                        n_out.status    = STAT_EMPTY;
                    end else begin
                        n_scan  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // the store is frozen, wait for the token to reach the chain end
                n_scan = r_scan + IDX_W'(1);
                if (r_scan == IDX_W'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = STAT_DEQUEUED;
                    n_out.value_out    = $signed(VALUE_FLD_W'(w_tok_d[DEPTH]));
                    n_out.priority_out = PRI_FLD_W'(w_tok_p[DEPTH]);
                    n_count            = r_count - CNT_W'(1);
                    n_out.occupancy    = OCC_W'(r_count - CNT_W'(1));
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: design/uapq_cell.sv
// one storage cell of the priority queue chain: holds a pair and forwards the
// running best-priority token to the next cell; depends on uapq_pkg
module uapq_cell
    import uapq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int PRI_W = PRI_W_DEF,
    parameter int VAL_W = VAL_W_DEF,
    parameter int IDX_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_wr_val,
    input  logic [PRI_W-1:0] i_wr_pri,
    input  logic [VAL_W-1:0] i_nb_val,
    input  logic [PRI_W-1:0] i_nb_pri,
    input  logic             i_tok_valid,
    input  logic [PRI_W-1:0] i_tok_pri,
    input  logic [VAL_W-1:0] i_tok_val,
    input  logic [IDX_W-1:0] i_tok_idx,
    output logic [VAL_W-1:0] o_val,
    output logic [PRI_W-1:0] o_pri,
    output logic             o_tok_valid,
    output logic [PRI_W-1:0] o_tok_pri,
    output logic [VAL_W-1:0] o_tok_val,
    output logic [IDX_W-1:0] o_tok_idx
);

    logic [VAL_W-1:0] r_val;
    logic [PRI_W-1:0] r_pri;
    logic             r_tok_valid;
    logic [PRI_W-1:0] r_tok_pri;
    logic [VAL_W-1:0] r_tok_val;
    logic [IDX_W-1:0] r_tok_idx;
    logic             w_take;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_val <= i_wr_val;
            r_pri <= i_wr_pri;
        end else if (i_ctl.shift) begin
            r_val <= i_nb_val;
            r_pri <= i_nb_pri;
        end
    end

    // later entries win ties, hence >= as the token moves up the chain
    assign w_take = i_ctl.valid && (!i_tok_valid || (r_pri >= i_tok_pri));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid || i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tok_pri <= r_pri;
            r_tok_val <= r_val;
            r_tok_idx <= IDX_W'(IDX);
        end else begin
            r_tok_pri <= i_tok_pri;
            r_tok_val <= i_tok_val;
            r_tok_idx <= i_tok_idx;
        end
    end

    assign o_val       = r_val;
    assign o_pri       = r_pri;
    assign o_tok_valid = r_tok_valid;
    assign o_tok_pri   = r_tok_pri;
    assign o_tok_val   = r_tok_val;
    assign o_tok_idx   = r_tok_idx;

endmodule

FILE: design/uapq_checker.sv
// port-level checks for the priority queue top level, attached by bind
// depends on uapq_pkg and unordered_array_priority_queue
module uapq_checker
    import uapq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // occupancy never passes the depth
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy beyond depth");

    // only a dequeue returns data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != STAT_DEQUEUED)
        |-> (o_out.value_out == '0) && (o_out.priority_out == '0))
        else $error("data on a non-dequeue result");

    // full and empty agree with occupancy
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid
        |-> ((o_out.status != STAT_FULL) || (o_out.occupancy == OCC_W'(DEPTH)))
         && ((o_out.status != STAT_EMPTY) || (o_out.occupancy == '0)))
        else $error("full or empty status with wrong occupancy");

    // an enqueue leaves at least one entry, a dequeue leaves room
    a_enq_deq_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid
        |-> ((o_out.status != STAT_ENQUEUED) || (o_out.occupancy != '0))
         && ((o_out.status != STAT_DEQUEUED) || (o_out.occupancy < OCC_W'(DEPTH))))
        else $error("enqueue or dequeue status with wrong occupancy");

endmodule

bind unordered_array_priority_queue uapq_checker #(.DEPTH(DEPTH)) u_uapq_checker (.*);

FILE: tb/unordered_array_priority_queue_tb.sv
// self-checking testbench for the unordered array priority queue
// depends on uapq_pkg and unordered_array_priority_queue; directed cases, then random traffic
// with random idling on both sides, checked against a behavioral copy of the queue
`timescale 1ns / 100ps

module unordered_array_priority_queue_tb;
    import uapq_pkg::*;

    localparam int CLK_HALF  = 6;
    localparam int MAX_IDLE  = 16;
    localparam int LIMIT     = 400000;
    localparam int MAX_SHOWN = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    unordered_array_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // behavioral copy of the store, oldest entry first
    logic signed [VALUE_FLD_W-1:0] held_val[$];
    logic        [PRI_FLD_W-1:0]   held_pri[$];

    t_out pending_outcomes[$];

    int  mismatches   = 0;
    int  checked      = 0;
    int  cycle_count  = 0;
    int  rx_hold      = 0;
    bit  quiet_tx     = 0;
    bit  quiet_rx     = 0;
    int  n_enq        = 0;
    int  n_full       = 0;
    int  n_deq        = 0;
    int  n_empty      = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_out predict_outcome(input t_in req);
        t_out res;
        int   best;
        res = '0;
        if (req.operation == OP_ENQUEUE) begin
            if (held_val.size() >= DEPTH_DEF) begin
                res.status = STAT_FULL;
            end else begin
                held_val.push_back(req.value_in);
                held_pri.push_back(req.priority_in);
                res.status = STAT_ENQUEUED;
            end
        end else if (held_val.size() == 0) begin
            res.status = STAT_EMPTY;
        end else begin
            // highest priority wins, later entry wins a tie
            best = 0;
            for (int i = 1; i < held_val.size(); i++)
                if (held_pri[i] >= held_pri[best])
                    best = i;
            res.value_out    = held_val[best];
            res.priority_out = held_pri[best];
            held_val.delete(best);
            held_pri.delete(best);
            res.status = STAT_DEQUEUED;
        end
        res.occupancy = OCC_W'(held_val.size());
        return res;
    endfunction

    // called right after a rising edge; leaves valid high after the accepting edge
    task automatic send_request(input t_in req);
        int   gap;
        t_out want;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_IDLE);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        want = predict_outcome(req);
        case (want.status)
            STAT_ENQUEUED: n_enq++;
            STAT_FULL:     n_full++;
            STAT_DEQUEUED: n_deq++;
            default:       n_empty++;
        endcase
        pending_outcomes.push_back(want);
    endtask

    task automatic wait_all_returned();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic op, input logic [31:0] val, input logic [7:0] pri);
        t_in req;
        req.operation   = op;
        req.value_in    = val;
        req.priority_in = pri;
        send_request(req);
    endtask

    // receiver stalls, redrawn after every accepted result
    always @(negedge i_clk) begin
        i_out_ready <= (rx_hold == 0);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch on %s at cycle %0d: expected %h, got %h",
                         name, cycle_count, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rx_hold <= quiet_rx ? 0 : $urandom_range(0, MAX_IDLE);
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected transaction at cycle %0d: %p", cycle_count, o_out);
            end else begin
                want = pending_outcomes.pop_front();
                checked++;
                check_field("status", want.status, o_out.status);
                check_field("value_out", want.value_out, o_out.value_out);
                check_field("priority_out", want.priority_out, o_out.priority_out);
                check_field("occupancy", want.occupancy, o_out.occupancy);
            end
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    task automatic test_empty_dequeue();
        send_pair(OP_DEQUEUE, $urandom, PRI_FLD_W'($urandom_range(0, 255)));
        send_pair(OP_DEQUEUE, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_fill_and_full();
        // several ties at the top and at zero priority
        send_pair(OP_ENQUEUE, 32'h7FFF_FFFF, 8'd255);
        send_pair(OP_ENQUEUE, 32'h8000_0000, 8'd0);
        send_pair(OP_ENQUEUE, 32'h0000_0000, 8'd255);
        send_pair(OP_ENQUEUE, 32'hFFFF_FFFF, 8'h80);
        send_pair(OP_ENQUEUE, 32'h0000_0001, 8'd0);
        send_pair(OP_ENQUEUE, 32'h5555_5555, 8'd255);
        send_pair(OP_ENQUEUE, 32'hAAAA_AAAA, 8'd1);
        send_pair(OP_ENQUEUE, 32'h1234_5678, 8'd254);
        send_pair(OP_ENQUEUE, 32'hDEAD_BEEF, 8'd255);
        send_pair(OP_ENQUEUE, 32'h0, 8'd0);
    endtask

    task automatic test_priority_order();
        for (int i = 0; i <= DEPTH_DEF; i++)
            send_pair(OP_DEQUEUE, $urandom, PRI_FLD_W'($urandom_range(0, 255)));
    endtask

    task automatic test_single_entry();
        send_pair(OP_ENQUEUE, 32'hCAFE_0001, 8'd7);
        send_pair(OP_DEQUEUE, 32'h0, 8'd0);
    endtask

    task automatic test_pause_until_idle();
        for (int i = 0; i < 5; i++)
            send_pair(OP_ENQUEUE, $urandom, PRI_FLD_W'($urandom_range(0, 255)));
        wait_all_returned();
        for (int i = 0; i < 3; i++)
            send_pair(OP_DEQUEUE, $urandom, PRI_FLD_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic(input int n_items);
        int  sent;
        int  run_len;
        int  bias;
        t_in req;
        sent = 0;
        while (sent < n_items) begin
            run_len = $urandom_range(8, 40);
            case ($urandom_range(0, 4))
                0: bias = 90;
                1: bias = 70;
                2: bias = 50;
                3: bias = 30;
                default: bias = 10;
            endcase
            // some stretches run with no idling at all
            quiet_tx = ($urandom_range(0, 4) == 0);
            quiet_rx = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                req.operation = ($urandom_range(0, 99) < bias) ? OP_ENQUEUE : OP_DEQUEUE;
                req.value_in  = $urandom;
                // narrow priorities give plenty of ties
                req.priority_in = PRI_FLD_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                                  : $urandom_range(0, 255));
                send_request(req);
                sent++;
            end
        end
        quiet_tx = 0;
        quiet_rx = 0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_empty_dequeue();
        test_fill_and_full();
        test_priority_order();
        test_single_entry();
        test_pause_until_idle();
        test_random_traffic(900);

        wait_all_returned();
        repeat (DEPTH_DEF + 4) @(posedge i_clk);

        $display("run covered %0d enqueues, %0d rejected on full, %0d dequeues, %0d on empty",
                 n_enq, n_full, n_deq, n_empty);
        $display("%0d results compared, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
